// ===== sv/ppm4fd_pkg.sv =====
package ppm4fd_pkg;

  localparam logic [7:0] NO_EDGE        = 8'hFF;
  localparam logic [7:0] CODE_INVENTORY = 8'h01;
  localparam logic [7:0] CODE_READ      = 8'h20;

  // buffer slots that the end-of-frame result reports
  localparam int CMD_BYTE_POS = 1;
  localparam int ARG_BYTE_POS = 10;

  localparam logic [2:0] REG_SOF_LOW  = 3'd0;
  localparam logic [2:0] REG_SOF_HIGH = 3'd1;
  localparam logic [2:0] REG_THR_ONE  = 3'd2;
  localparam logic [2:0] REG_THR_TWO  = 3'd3;
  localparam logic [2:0] REG_THR_THREE = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYM0,
    PH_SYM1,
    PH_SYM2,
    PH_SYM3
  } phase_t;

  typedef enum logic [1:0] {
    SYM_ZERO  = 2'd0,
    SYM_ONE   = 2'd1,
    SYM_TWO   = 2'd2,
    SYM_THREE = 2'd3
  } sym_t;

  typedef enum logic [1:0] {
    CLS_INVENTORY = 2'd0,
    CLS_READ      = 2'd1,
    CLS_OTHER     = 2'd2
  } cmd_class_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOF  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] data_byte;
    logic [4:0] byte_position;
    logic [5:0] frame_byte_count;
    logic [7:0] command_code;
    cmd_class_t command_class;
    logic [7:0] read_argument;
    logic       overflow_flag;
  } res_t;

endpackage

// ===== sv/ppm_one_of_four_frame_decoder.sv =====
// channel   | ports                                   | moves
// ----------+-----------------------------------------+-------------------------------
// in        | in_valid, in_ready, in_slot_edge_time   | one slot tick per item
// out       | out_valid, out_ready, out_* fields      | data byte or end-of-frame item
// cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data | threshold / window writes
//
// one slot item is accepted per cycle while in_ready is high; a result goes to
// the output register, or to the second entry while the first is held. the
// two-entry output buffer keeps input flowing while one result waits; in_ready
// drops only when both are occupied. cfg_ready is always high. reset is
// synchronous and clears phase, counters, captured cmd/arg bytes and registers to defaults.
module ppm_one_of_four_frame_decoder
  import ppm4fd_pkg::*;
#(
  parameter int BUFFER_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_slot_edge_time,

  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_result_kind,
  output logic [7:0] out_data_byte,
  output logic [4:0] out_byte_position,
  output logic [5:0] out_frame_byte_count,
  output logic [7:0] out_command_code,
  output logic [1:0] out_command_class,
  output logic [7:0] out_read_argument,
  output logic       out_overflow_flag
);

  localparam int WIDX_W = $clog2(BUFFER_BYTES + 1);

  logic [7:0] sof_low_r, sof_high_r, thr_one_r, thr_two_r, thr_three_r;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic        ovf_r, ovf_nxt;
  // only buffer slots 1 and 10 are ever read back
  logic [7:0]  cmd_byte_r, cmd_byte_nxt;
  logic [7:0]  arg_byte_r, arg_byte_nxt;

  logic        in_fire;
  logic        buf_full;
  logic        res_push;
  res_t        res;
  res_t        out_res;
  sym_t        sym;
  logic [7:0]  shifted;

  assign cfg_ready = 1'b1;
  assign in_ready  = !buf_full;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_low_r   <= 8'd80;
      sof_high_r  <= 8'd108;
      thr_one_r   <= 8'd40;
      thr_two_r   <= 8'd80;
      thr_three_r <= 8'd116;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOF_LOW:   sof_low_r   <= cfg_data;
        REG_SOF_HIGH:  sof_high_r  <= cfg_data;
        REG_THR_ONE:   thr_one_r   <= cfg_data;
        REG_THR_TWO:   thr_two_r   <= cfg_data;
        REG_THR_THREE: thr_three_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_slot_edge_time < thr_one_r) begin
      sym = SYM_ZERO;
    end else if (in_slot_edge_time < thr_two_r) begin
      sym = SYM_ONE;
    end else if (in_slot_edge_time < thr_three_r) begin
      sym = SYM_TWO;
    end else begin
      sym = SYM_THREE;
    end
  end

  assign shifted = {sym, shift_r[7:2]};

  always_comb begin
    phase_nxt    = phase_r;
    shift_nxt    = shift_r;
    widx_nxt     = widx_r;
    ovf_nxt      = ovf_r;
    cmd_byte_nxt = cmd_byte_r;
    arg_byte_nxt = arg_byte_r;
    res_push     = 1'b0;
    res          = '0;
    if (in_fire) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_slot_edge_time > sof_low_r && in_slot_edge_time < sof_high_r) begin
            phase_nxt = PH_SYM0;
            shift_nxt = '0;
            widx_nxt  = '0;
            ovf_nxt   = 1'b0;
          end
        end
        PH_SYM0, PH_SYM1, PH_SYM2, PH_SYM3: begin
          if (in_slot_edge_time == NO_EDGE) begin
            // partial byte dropped, frame summary goes out
            phase_nxt              = PH_IDLE;
            res_push               = 1'b1;
            res.result_kind        = KIND_EOF;
            res.frame_byte_count   = 6'(widx_r);
            res.command_code       = cmd_byte_r;
            if (cmd_byte_r == CODE_INVENTORY) begin
              res.command_class = CLS_INVENTORY;
            end else if (cmd_byte_r == CODE_READ) begin
              res.command_class = CLS_READ;
            end else begin
              res.command_class = CLS_OTHER;
            end
            res.read_argument      = arg_byte_r;
            res.overflow_flag      = ovf_r;
          end else if (phase_r != PH_SYM3) begin
            phase_nxt = phase_t'(phase_r + 3'd1);
            shift_nxt = shifted;
          end else begin
            phase_nxt       = PH_SYM0;
            shift_nxt       = '0;
            res_push        = 1'b1;
            res.result_kind = KIND_DATA;
            res.data_byte   = shifted;
            if (widx_r < WIDX_W'(BUFFER_BYTES)) begin
              if (widx_r == WIDX_W'(CMD_BYTE_POS)) begin
                cmd_byte_nxt = shifted;
              end
              if (widx_r == WIDX_W'(ARG_BYTE_POS)) begin
                arg_byte_nxt = shifted;
              end
              res.byte_position = 5'(widx_r);
              widx_nxt          = widx_r + WIDX_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
            res.overflow_flag = ovf_nxt;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      shift_r    <= '0;
      widx_r     <= '0;
      ovf_r      <= 1'b0;
      cmd_byte_r <= '0;
      arg_byte_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      shift_r    <= shift_nxt;
      widx_r     <= widx_nxt;
      ovf_r      <= ovf_nxt;
      cmd_byte_r <= cmd_byte_nxt;
      arg_byte_r <= arg_byte_nxt;
    end
  end

  ppm4fd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_result_kind      = out_res.result_kind;
  assign out_data_byte        = out_res.data_byte;
  assign out_byte_position    = out_res.byte_position;
  assign out_frame_byte_count = out_res.frame_byte_count;
  assign out_command_code     = out_res.command_code;
  assign out_command_class    = out_res.command_class;
  assign out_read_argument    = out_res.read_argument;
  assign out_overflow_flag    = out_res.overflow_flag;

endmodule

// ===== sv/ppm4fd_out_buf.sv =====
module ppm4fd_out_buf
  import ppm4fd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic main_valid_r;
  logic skid_valid_r;
  res_t main_data_r;
  res_t skid_data_r;
  logic pop;

  assign pop       = main_valid_r && out_ready;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // no push can arrive while the skid entry is held
      if (pop) begin
        main_data_r  <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_data_r  <= push_data;
        main_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

endmodule
